FILE: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared constants, types and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MaxUnitsDefault    = 256;
    localparam int HeaderBytesDefault = 16;
    localparam int OrderW             = 4;
    localparam int OffW               = 12;
    localparam logic [OrderW-1:0] PoolOrderReset = 4'd12;

    localparam logic [1:0] StatusOk      = 2'd0;
    localparam logic [1:0] StatusRefused = 2'd1;
    localparam logic [1:0] StatusBadFree = 2'd2;

    localparam logic CmdAlloc = 1'b0;
    localparam logic CmdFree  = 1'b1;

    typedef enum logic [3:0] {
        t_ST_CLEAR,
        t_ST_IDLE,
        t_ST_SCAN_RD,
        t_ST_SCAN,
        t_ST_SPLIT_RD,
        t_ST_SPLIT,
        t_ST_COUNT_RD,
        t_ST_COUNT,
        t_ST_MERGE_RD,
        t_ST_MERGE,
        t_ST_OUT
    } t_state;

    typedef struct packed {
        logic            starts;
        logic            free;
        logic [OrderW-1:0] order;
    } t_unit;

    function automatic int clog2_min(input int v);
        int s;
        s = 0;
        while ((1 << s) < v) s++;
        return s;
    endfunction

endpackage

FILE: hw/rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocates and frees power-of-two blocks of a pool of header-sized units.
// ----------------------------------------------------------------------------
// One request enters on the s_axis channel: tuser carries the command
// (0 allocate, 1 free) and tdata the requested bytes and the user offset.
// One result leaves on the m_axis channel with status and granted offset.
// The block handles one request at a time and is not ready meanwhile.
// A request walks the unit descriptor memory through its single port,
// with a read state and a work state per descriptor visited: a first-fit
// scan of up to MAX_UNITS blocks, up to log2(MAX_UNITS) splits, a second
// scan counting free blocks, and for a free up to log2(MAX_UNITS) merges.
// After reset, and after every pool_order write, a clearing pass writes
// all MAX_UNITS descriptors, one per cycle, before requests are taken.
// A finished result waits in an output register, so a stalled receiver
// holds the next request only once that request has its result ready.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
    parameter int MAX_UNITS    = bba_pkg::MaxUnitsDefault,
    parameter int HEADER_BYTES = bba_pkg::HeaderBytesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: request_bytes[11:0], user_offset[23:12].
    input  logic [23:0] s_axis_tdata,
    // Fields from bit 0: command.
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: granted_offset[11:0], padding zeros.
    output logic [15:0] m_axis_tdata,
    // Fields from bit 0: status[1:0].
    output logic [1:0]  m_axis_tuser
);
    localparam int AW    = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int GS    = bba_pkg::clog2_min(HEADER_BYTES);
    localparam int CW    = AW + 1;
    localparam int SW    = 14;

    // Clamp the order to 5..12, then lower it until the pool fits in MAX_UNITS granules.
    function automatic logic [3:0] clamp_order(input logic [3:0] v);
        int o;
        o = int'(v);
        if (o < 5) o = 5;
        if (o > 12) o = 12;
        while (o > 0 && (longint'(1) << o) > (longint'(MAX_UNITS) << GS)) o--;
        return 4'(o);
    endfunction

    bba_pkg::t_state r_state, n_state;
    logic [3:0]   r_pool, n_pool;
    logic [CW-1:0] r_clr, n_clr;
    logic [SW-1:0] r_off, n_off;
    logic [SW-1:0] r_sel, n_sel;
    logic [SW-1:0] r_need, n_need;
    logic [SW-1:0] r_size, n_size;
    logic [CW:0]  r_steps, n_steps;
    logic [1:0]   r_frees, n_frees;
    logic [3:0]   r_uord, n_uord;
    logic         r_found, n_found;
    logic [1:0]   r_stat, n_stat;
    logic [11:0]  r_gout, n_gout;
    logic [1:0]   r_ostat, n_ostat;
    logic [11:0]  r_ogout, n_ogout;
    logic         r_cmd, n_cmd;
    logic         r_done, n_done;

    logic          w_we;
    logic [AW-1:0] w_addr;
    bba_pkg::t_unit w_wdata, w_rd;

    bba_store #(.MAX_UNITS(MAX_UNITS), .AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rd)
    );

    logic [SW-1:0] w_pool_sz, w_rsize;
    assign w_pool_sz = SW'(1) << r_pool;
    assign w_rsize   = SW'(1) << w_rd.order;

    function automatic logic [AW-1:0] unit_of(input logic [SW-1:0] off);
        logic [SW-1:0] u;
        u = off >> GS;
        return (u < SW'(MAX_UNITS)) ? u[AW-1:0] : '0;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::t_ST_CLEAR;
            r_pool  <= clamp_order(bba_pkg::PoolOrderReset);
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pool  <= n_pool;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
        r_off   <= n_off;
        r_sel   <= n_sel;
        r_need  <= n_need;
        r_size  <= n_size;
        r_steps <= n_steps;
        r_frees <= n_frees;
        r_uord  <= n_uord;
        r_found <= n_found;
        r_stat  <= n_stat;
        r_gout  <= n_gout;
        r_ostat <= n_ostat;
        r_ogout <= n_ogout;
        r_cmd   <= n_cmd;
    end

    always_comb begin
        logic [SW-1:0] v_off;
        n_state = r_state;
        n_pool  = r_pool;
        n_clr   = r_clr;
        n_off   = r_off;
        n_sel   = r_sel;
        n_need  = r_need;
        n_size  = r_size;
        n_steps = r_steps;
        n_frees = r_frees;
        n_uord  = r_uord;
        n_found = r_found;
        n_stat  = r_stat;
        n_gout  = r_gout;
        n_ostat = r_ostat;
        n_ogout = r_ogout;
        n_cmd   = r_cmd;
        n_done  = r_done;
        w_we    = 1'b0;
        w_addr  = unit_of(r_off);
        w_wdata = '0;
        v_off   = '0;
        s_axis_tready = 1'b0;
        if (m_axis_tvalid && m_axis_tready) n_done = 1'b0;

        unique case (r_state)
            bba_pkg::t_ST_CLEAR: begin
                w_we   = 1'b1;
                w_addr = r_clr[AW-1:0];
                if (r_clr == '0) begin
                    w_wdata = '{starts: 1'b1, free: 1'b1, order: r_pool};
                end
                n_clr = r_clr + CW'(1);
                if (r_clr == CW'(MAX_UNITS - 1)) begin
                    n_clr   = '0;
                    n_state = bba_pkg::t_ST_IDLE;
                end
            end
            bba_pkg::t_ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_cmd   = s_axis_tuser;
                    n_need  = SW'(s_axis_tdata[11:0]) + SW'(HEADER_BYTES);
                    n_off   = '0;
                    n_steps = '0;
                    n_found = 1'b0;
                    n_gout  = '0;
                    if (s_axis_tuser == bba_pkg::CmdAlloc) begin
                        n_state = bba_pkg::t_ST_SCAN_RD;
                    end else begin
                        v_off = SW'(s_axis_tdata[23:12]) - SW'(HEADER_BYTES);
                        n_off = v_off;
                        if (s_axis_tdata[23:12] < 12'(HEADER_BYTES)
                            || (v_off & ((SW'(1) << GS) - SW'(1))) != '0
                            || v_off >= w_pool_sz
                            || (v_off >> GS) >= SW'(MAX_UNITS)) begin
                            n_stat  = bba_pkg::StatusBadFree;
                            n_state = bba_pkg::t_ST_OUT;
                        end else begin
                            n_found = 1'b1;
                            n_state = bba_pkg::t_ST_MERGE_RD;
                        end
                    end
                end
            end
            bba_pkg::t_ST_SCAN_RD: begin
                n_state = bba_pkg::t_ST_SCAN;
            end
            bba_pkg::t_ST_SCAN: begin
                if (w_rd.free && w_rsize >= r_need) begin
                    n_sel   = r_off;
                    n_size  = w_rsize;
                    n_uord  = w_rd.order;
                    n_state = (r_need + SW'(HEADER_BYTES) <= w_rsize)
                              ? bba_pkg::t_ST_SPLIT : bba_pkg::t_ST_COUNT_RD;
                    n_off   = '0;
                    n_steps = '0;
                    n_frees = '0;
                end else begin
                    n_off   = r_off + w_rsize;
                    n_steps = r_steps + (CW+1)'(1);
                    if (n_off >= w_pool_sz || n_steps > (CW+1)'(MAX_UNITS)) begin
                        n_stat  = bba_pkg::StatusRefused;
                        n_state = bba_pkg::t_ST_OUT;
                    end else begin
                        n_state = bba_pkg::t_ST_SCAN_RD;
                    end
                end
            end
            bba_pkg::t_ST_SPLIT: begin
                // Write the right half, then shrink the left one.
                if ((r_size >> 1) >= r_need && r_uord != '0) begin
                    w_we    = 1'b1;
                    w_addr  = unit_of(r_sel + (r_size >> 1));
                    w_wdata = '{starts: 1'b1, free: 1'b1, order: r_uord - 4'd1};
                    n_uord  = r_uord - 4'd1;
                    n_size  = r_size >> 1;
                end else begin
                    w_we    = 1'b1;
                    w_addr  = unit_of(r_sel);
                    w_wdata = '{starts: 1'b1, free: 1'b1, order: r_uord};
                    n_state = bba_pkg::t_ST_COUNT_RD;
                end
            end
            bba_pkg::t_ST_SPLIT_RD: begin
                n_state = bba_pkg::t_ST_SPLIT;
            end
            bba_pkg::t_ST_COUNT_RD: begin
                n_state = bba_pkg::t_ST_COUNT;
            end
            bba_pkg::t_ST_COUNT: begin
                if (w_rd.free && r_frees != 2'd2) n_frees = r_frees + 2'd1;
                n_off   = r_off + w_rsize;
                n_steps = r_steps + (CW+1)'(1);
                if (n_off >= w_pool_sz || n_steps > (CW+1)'(MAX_UNITS)
                    || n_frees == 2'd2) begin
                    if (n_frees <= 2'd1) begin
                        n_stat = bba_pkg::StatusRefused;
                    end else begin
                        w_we    = 1'b1;
                        w_addr  = unit_of(r_sel);
                        w_wdata = '{starts: 1'b1, free: 1'b0, order: r_uord};
                        n_stat  = bba_pkg::StatusOk;
                        n_gout  = 12'(r_sel + SW'(HEADER_BYTES));
                    end
                    n_state = bba_pkg::t_ST_OUT;
                end else begin
                    n_state = bba_pkg::t_ST_COUNT_RD;
                end
            end
            bba_pkg::t_ST_MERGE_RD: begin
                n_state = bba_pkg::t_ST_MERGE;
            end
            bba_pkg::t_ST_MERGE: begin
                // r_found marks the first read: the freed block itself.
                if (r_found) begin
                    n_found = 1'b0;
                    if (!w_rd.starts || w_rd.free) begin
                        n_stat  = bba_pkg::StatusBadFree;
                        n_state = bba_pkg::t_ST_OUT;
                    end else begin
                        w_we    = 1'b1;
                        w_wdata = '{starts: 1'b1, free: 1'b1, order: w_rd.order};
                        n_uord  = w_rd.order;
                        n_size  = w_rsize;
                        n_stat  = bba_pkg::StatusOk;
                        n_sel   = r_off ^ w_rsize;
                        w_addr  = unit_of(r_off);
                        if (w_rd.order >= r_pool || (r_off ^ w_rsize) >= w_pool_sz)
                            n_state = bba_pkg::t_ST_OUT;
                        else
                            n_state = bba_pkg::t_ST_SPLIT_RD;
                    end
                end else begin
                    n_state = bba_pkg::t_ST_OUT;
                end
            end
            default: begin
                n_state = bba_pkg::t_ST_IDLE;
                n_done  = 1'b1;
            end
        endcase

        // Merge step: SPLIT_RD reads the buddy when a free is in progress.
        if (r_state == bba_pkg::t_ST_MERGE && r_found && n_state == bba_pkg::t_ST_SPLIT_RD)
            w_addr = unit_of(r_off);
        if (r_state == bba_pkg::t_ST_SPLIT_RD && r_cmd == bba_pkg::CmdFree) begin
            w_addr  = unit_of(r_sel);
            n_state = bba_pkg::t_ST_COUNT_RD;
        end
        if (r_cmd == bba_pkg::CmdFree && r_state == bba_pkg::t_ST_COUNT_RD) begin
            w_addr  = unit_of(r_sel);
            n_state = bba_pkg::t_ST_COUNT;
        end
        if (r_cmd == bba_pkg::CmdFree && r_state == bba_pkg::t_ST_COUNT) begin
            w_we    = 1'b0;
            n_frees = r_frees;
            n_steps = r_steps;
            n_off   = r_off;
            n_gout  = '0;
            n_stat  = bba_pkg::StatusOk;
            if (w_rd.starts && w_rd.free && w_rd.order == r_uord) begin
                // Clear the higher unit, then grow the lower one.
                w_we    = 1'b1;
                w_addr  = unit_of((r_off < r_sel) ? r_sel : r_off);
                w_wdata = '0;
                n_off   = (r_off < r_sel) ? r_off : r_sel;
                n_uord  = r_uord + 4'd1;
                n_size  = r_size << 1;
                n_state = bba_pkg::t_ST_SPLIT;
            end else begin
                n_state = bba_pkg::t_ST_OUT;
            end
        end
        if (r_cmd == bba_pkg::CmdFree && r_state == bba_pkg::t_ST_SPLIT) begin
            w_we    = 1'b1;
            w_addr  = unit_of(r_off);
            w_wdata = '{starts: 1'b1, free: 1'b1, order: r_uord};
            n_uord  = r_uord;
            n_size  = r_size;
            n_sel   = r_off ^ r_size;
            if (r_uord >= r_pool || (r_off ^ r_size) >= w_pool_sz)
                n_state = bba_pkg::t_ST_OUT;
            else
                n_state = bba_pkg::t_ST_SPLIT_RD;
        end

        if (r_state == bba_pkg::t_ST_OUT) begin
            if (!r_done || m_axis_tready) begin
                n_state = bba_pkg::t_ST_IDLE;
                n_done  = 1'b1;
                n_ostat = r_stat;
                n_ogout = (r_cmd == bba_pkg::CmdAlloc && r_stat == bba_pkg::StatusOk)
                          ? r_gout : '0;
            end else begin
                n_state = bba_pkg::t_ST_OUT;
            end
        end

        if (i_cfg_we) begin
            n_pool  = clamp_order(i_cfg_wdata);
            n_clr   = '0;
            n_state = bba_pkg::t_ST_CLEAR;
        end
    end

    assign m_axis_tvalid = r_done;
    assign m_axis_tdata  = {4'd0, r_ogout};
    assign m_axis_tuser  = r_ostat;
endmodule

FILE: hw/rtl/bba_store.sv
// ----------------------------------------------------------------------------
// Unit descriptor store
// One-port memory of per-granule block descriptors with registered read.
// ----------------------------------------------------------------------------
module bba_store #(
    parameter int MAX_UNITS = bba_pkg::MaxUnitsDefault,
    parameter int AW        = 8
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_addr,
    input  bba_pkg::t_unit        i_wdata,
    output bba_pkg::t_unit        o_rdata
);
    bba_pkg::t_unit r_mem [MAX_UNITS];
    bba_pkg::t_unit r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
